[rtl/cfr_pkg.sv]
// Package for the checksummed frame receiver.
// Holds shared types, codes and constants; no dependencies.
`default_nettype none

package cfr_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 40;
    localparam int BYTE_W              = 8;
    localparam int INDEX_W             = 6;
    // Wide enough for length + 3 with length up to 255.
    localparam int LEN_CMP_W           = 9;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [INDEX_W-1:0] t_index;

    localparam t_byte CHECK_BASE    = 8'hFF;
    localparam t_byte TIMEOUT_RESET = 8'd2;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEND = 3'b010,
        S_ERR  = 3'b100
    } t_state;

endpackage

`default_nettype wire

[rtl/cfr_if.sv]
// Valid/ready channels of the checksummed frame receiver.
// Depends on cfr_pkg for payload types.
`default_nettype none

interface cfr_in_if;
    logic              valid;
    logic              ready;
    cfr_pkg::t_cmd     command;
    cfr_pkg::t_byte    rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface cfr_out_if;
    logic              valid;
    logic              ready;
    cfr_pkg::t_byte    frame_byte;
    cfr_pkg::t_index   byte_index;
    logic              last;
    logic              checksum_ok;

    modport source (output valid, output frame_byte, output byte_index, output last,
                    output checksum_ok, input ready);
    modport sink   (input valid, input frame_byte, input byte_index, input last,
                    input checksum_ok, output ready);
endinterface

`default_nettype wire

[rtl/cfr_frame_mem.sv]
// Frame byte store: one write port, one read port, registered read data.
// Depends on cfr_pkg for the byte type.
`default_nettype none

module cfr_frame_mem #(
    parameter int DEPTH = cfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire cfr_pkg::t_byte           i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output cfr_pkg::t_byte                o_rdata
);
    import cfr_pkg::*;

    t_byte r_mem [DEPTH];
    t_byte r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Hold the last read word until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[rtl/checksummed_frame_receiver_core.sv]
// Top level of the checksummed frame receiver: framing, checksum and readout.
// Depends on cfr_pkg, cfr_if (channels) and cfr_frame_mem.
//
// Each input item (a received byte or a timeout tick) is taken only while idle.
// Bytes go into a single-port-write, single-port-read frame store; the running
// sum and the frame length are kept in registers, so a frame's checksum is
// known the moment its last byte arrives. A good frame is then read back from
// the store one byte per cycle while the sink is ready (the read port sets
// this), type byte first, while input is held off: a frame with L payload
// bytes gives L+1 results. A bad checksum gives one error result.
// No new input item is taken until the last result of a frame is delivered.
// The store needs no clearing after reset: only bytes of the current frame
// are read.
`default_nettype none

module checksummed_frame_receiver_core #(
    parameter int MAX_FRAME_BYTES = cfr_pkg::MAX_FRAME_BYTES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    cfr_in_if.sink              i_in,
    cfr_out_if.source           o_out,
    input  wire logic           i_cfg_we,
    input  wire cfr_pkg::t_byte i_cfg_wdata
);
    import cfr_pkg::*;

    localparam int AW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = $clog2(MAX_FRAME_BYTES + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    t_byte           r_countdown, n_countdown;
    t_byte           r_sum, n_sum;
    t_byte           r_len, n_len;
    t_index          r_idx, n_idx;
    t_byte           r_timeout;

    logic            in_fire, out_fire;
    logic            is_byte;
    logic            store_ok;
    logic [CW-1:0]   count_inc;
    t_byte           len_eff;
    t_byte           cd_dec;
    logic            complete;
    logic            cks_ok;
    logic            run_last;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic            mem_re;
    logic [AW-1:0]   mem_raddr;
    t_byte           mem_rdata;

    cfr_frame_mem #(
        .DEPTH (MAX_FRAME_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in.rx_byte),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;
    assign out_fire   = o_out.valid && o_out.ready;
    assign is_byte    = (i_in.command == CMD_BYTE);

    assign store_ok  = (r_count < CW'(MAX_FRAME_BYTES));
    assign count_inc = store_ok ? r_count + CW'(1) : r_count;
    // The length byte is the one being stored when the store is empty.
    assign len_eff   = (r_count == '0) ? i_in.rx_byte : r_len;
    assign complete  = (LEN_CMP_W'(count_inc) >= LEN_CMP_W'(len_eff) + LEN_CMP_W'(3));
    // The byte that completes a frame is its checksum; the sum so far excludes it.
    assign cks_ok    = (i_in.rx_byte == CHECK_BASE - r_sum);
    assign cd_dec    = (r_countdown != '0) ? r_countdown - 8'd1 : r_countdown;
    assign run_last  = ({2'b00, r_idx} == r_len);

    assign mem_we    = in_fire && is_byte && store_ok;
    assign mem_waddr = r_count[AW-1:0];

    // Readout reads bytes 1..len+1; the checksum byte written on completion is
    // never among them, so read and write never meet on one entry.
    always_comb begin
        mem_re    = 1'b0;
        mem_raddr = AW'(1);
        if (r_state == S_IDLE) begin
            mem_re = in_fire && is_byte && complete && cks_ok;
        end else if (r_state == S_SEND) begin
            mem_re    = out_fire && !run_last;
            mem_raddr = AW'(7'(r_idx) + 7'd2);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_countdown = r_countdown;
        n_sum       = r_sum;
        n_len       = r_len;
        n_idx       = r_idx;
        case (r_state)
            S_IDLE: begin
                if (in_fire && is_byte) begin
                    n_count     = count_inc;
                    n_sum       = store_ok ? r_sum + i_in.rx_byte : r_sum;
                    n_len       = len_eff;
                    n_countdown = r_timeout;
                    if (complete) begin
                        // Empty the store either way; results follow.
                        n_count = '0;
                        n_sum   = '0;
                        n_idx   = '0;
                        n_state = cks_ok ? S_SEND : S_ERR;
                    end
                end else if (in_fire) begin
                    n_countdown = cd_dec;
                    if (r_count != '0 && cd_dec == '0) begin
                        n_count = '0;
                        n_sum   = '0;
                    end
                end
            end
            S_SEND: begin
                if (out_fire) begin
                    if (run_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + t_index'(1);
                    end
                end
            end
            S_ERR: begin
                if (out_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_countdown <= '0;
            r_sum       <= '0;
            r_timeout   <= TIMEOUT_RESET;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_countdown <= n_countdown;
            r_sum       <= n_sum;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
        r_idx <= n_idx;
    end

    assign o_out.valid       = (r_state == S_SEND) || (r_state == S_ERR);
    assign o_out.frame_byte  = (r_state == S_ERR) ? '0 : mem_rdata;
    assign o_out.byte_index  = (r_state == S_ERR) ? '0 : r_idx;
    assign o_out.last        = (r_state == S_ERR) ? 1'b1 : run_last;
    assign o_out.checksum_ok = (r_state == S_SEND);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_FRAME_BYTES))
        else $error("byte count above store depth");

    a_no_input_during_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while results pending");

    a_tick_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !is_byte) |=> !o_out.valid)
        else $error("tick produced a result");

    a_idx_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> ({2'b00, r_idx} <= r_len))
        else $error("readout index past frame length");

    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && o_out.last) |=> (r_state == S_IDLE))
        else $error("receiver not idle after last result");

endmodule

`default_nettype wire
